[hw/rtl/ssc_pkg.sv]
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, constants and lookup functions of the six-step commutator.
// ----------------------------------------------------------------------------
package ssc_pkg;

    // field widths
    localparam int TICKS_W    = 16;
    localparam int SCALE_W    = 8;
    localparam int SPEED_W    = TICKS_W + SCALE_W;
    localparam int ERR_W      = SPEED_W + 1;
    localparam int DUTY_W     = 8;
    localparam int STEP_W     = 3;
    localparam int INTEG_W    = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 40;

    // error / 100 as multiply by ceil(2^31 / 100) and shift; exact for |e| < 2^24
    localparam int     PI_DIV      = 100;
    localparam int     RECIP_SHIFT = 31;
    localparam int     RECIP_W     = 25;
    localparam longint RECIP_L     = ((64'd1 << RECIP_SHIFT) + PI_DIV - 1) / PI_DIV;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int     PROD_W      = SPEED_W + RECIP_W;
    localparam int     QUOT_W      = PROD_W - RECIP_SHIFT;

    // reset values
    localparam logic [SPEED_W-1:0] TARGET_SPEED_RST   = 24'd31250;
    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST    = 8'd240;
    localparam logic [DUTY_W-1:0]  REST_DUTY_RST      = 8'd70;
    localparam logic [DUTY_W-1:0]  MAX_DUTY_RST       = 8'd85;
    localparam logic [DUTY_W-1:0]  INTEGRAL_LIMIT_RST = 8'd100;
    localparam logic [DUTY_W-1:0]  FORCE_DUTY_RST     = 8'd70;
    localparam logic [DUTY_W-1:0]  DUTY_LEVEL_RST     = 8'd100;

    localparam logic [STEP_W-1:0] STEP_FIRST = 3'd0;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_NONE  = 3'd6;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_EDGE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_FORCE = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_SPEED   = 3'd0,
        CFG_SPEED_SCALE    = 3'd1,
        CFG_REST_DUTY      = 3'd2,
        CFG_MAX_DUTY       = 3'd3,
        CFG_INTEGRAL_LIMIT = 3'd4,
        CFG_FORCE_DUTY     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [SPEED_W-1:0] target_speed;
        logic [SCALE_W-1:0] speed_scale;
        logic [DUTY_W-1:0]  rest_duty;
        logic [DUTY_W-1:0]  max_duty;
        logic [DUTY_W-1:0]  integral_limit;
        logic [DUTY_W-1:0]  force_duty;
    } cfg_t;

    // zero-crossing decode: which step must precede, which step follows
    typedef struct packed {
        logic              known;
        logic [STEP_W-1:0] need_step;
        logic [STEP_W-1:0] nxt_step;
    } xing_t;

    // front stage 1 contents
    typedef struct packed {
        logic [1:0]         op;
        xing_t              xing;
        logic               sw_off;
        logic [SPEED_W-1:0] speed;
    } cls_t;

    // queued work item handed to the back end
    typedef struct packed {
        logic [1:0]              op;
        xing_t                   xing;
        logic                    sw_off;
        logic signed [ERR_W-1:0] err;
        logic                    err_neg;
        logic [QUOT_W-1:0]       quot;
    } work_t;

    function automatic xing_t xing_lookup(input logic [1:0] phase, input logic rising);
        xing_t x;
        x.known     = 1'b1;
        x.need_step = STEP_FIRST;
        x.nxt_step  = STEP_FIRST;
        case (phase)
            2'd0: begin
                x.need_step = rising ? 3'd5 : 3'd2;
                x.nxt_step  = rising ? 3'd4 : 3'd1;
            end
            2'd1: begin
                x.need_step = rising ? 3'd1 : 3'd4;
                x.nxt_step  = rising ? 3'd0 : 3'd3;
            end
            2'd2: begin
                x.need_step = rising ? 3'd3 : 3'd0;
                x.nxt_step  = rising ? 3'd2 : 3'd5;
            end
            default: begin
                x.known = 1'b0;
            end
        endcase
        return x;
    endfunction

    // bit 2k: high side of phase k, bit 2k+1: low side of phase k
    function automatic logic [5:0] bridge_pattern(input logic [STEP_W-1:0] step);
        logic [5:0] p;
        case (step)
            3'd0:    p = 6'b000110;
            3'd1:    p = 6'b010010;
            3'd2:    p = 6'b011000;
            3'd3:    p = 6'b001001;
            3'd4:    p = 6'b100001;
            3'd5:    p = 6'b100100;
            default: p = 6'b000000;
        endcase
        return p;
    endfunction

endpackage

[hw/rtl/ssc_front.sv]
// ----------------------------------------------------------------------------
// ssc_front
// Accepts input beats, decodes the edge sequence and works out the speed
// error and its quotient by 100 over two pipeline stages.
// ----------------------------------------------------------------------------
module ssc_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ssc_pkg::cfg_t                    cfg,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ssc_pkg::S_TUSER_W-1:0]    s_tuser,   // [1:0] operation
    input  logic [ssc_pkg::S_TDATA_W-1:0]    s_tdata,   // [1:0] phase, [2] rising,
                                                        // [18:3] elapsed_ticks,
                                                        // [19] switch_off
    output logic                             out_valid,
    input  logic                             out_ready,
    output ssc_pkg::work_t                   out_work
);

    logic           st1_valid_reg;
    ssc_pkg::cls_t  st1_reg;
    ssc_pkg::cls_t  st1_next;
    logic           st2_valid_reg;
    ssc_pkg::work_t st2_reg;
    ssc_pkg::work_t st2_next;
    logic           st2_ready;

    logic signed [ssc_pkg::ERR_W-1:0]  err;
    logic [ssc_pkg::SPEED_W-1:0]       err_mag;
    logic [ssc_pkg::PROD_W-1:0]        prod;

    assign st2_ready = !st2_valid_reg || out_ready;
    assign s_tready  = !st1_valid_reg || st2_ready;

    always_comb begin
        st1_next.op     = s_tuser;
        st1_next.xing   = ssc_pkg::xing_lookup(s_tdata[1:0], s_tdata[2]);
        st1_next.sw_off = s_tdata[19];
        st1_next.speed  = ssc_pkg::SPEED_W'(s_tdata[18:3]) *
                          ssc_pkg::SPEED_W'(cfg.speed_scale);
    end

    always_comb begin
        err     = $signed({1'b0, st1_reg.speed}) - $signed({1'b0, cfg.target_speed});
        err_mag = err[ssc_pkg::ERR_W-1] ? ssc_pkg::SPEED_W'(-err)
                                        : err[ssc_pkg::SPEED_W-1:0];
        prod    = ssc_pkg::PROD_W'(err_mag) * ssc_pkg::PROD_W'(ssc_pkg::RECIP);

        st2_next.op      = st1_reg.op;
        st2_next.xing    = st1_reg.xing;
        st2_next.sw_off  = st1_reg.sw_off;
        st2_next.err     = err;
        st2_next.err_neg = err[ssc_pkg::ERR_W-1];
        st2_next.quot    = prod[ssc_pkg::PROD_W-1:ssc_pkg::RECIP_SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                st1_valid_reg <= s_tvalid;
            end
            if (st2_ready) begin
                st2_valid_reg <= st1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            st1_reg <= st1_next;
        end
        if (st2_ready && st1_valid_reg) begin
            st2_reg <= st2_next;
        end
    end

    assign out_valid = st2_valid_reg;
    assign out_work  = st2_reg;

endmodule

[hw/rtl/ssc_queue.sv]
// ----------------------------------------------------------------------------
// ssc_queue
// Small FIFO of work items between the front and back ends.
// ----------------------------------------------------------------------------
module ssc_queue #(
    parameter int Depth = ssc_pkg::QUEUE_DEPTH     // 2 or more
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ssc_pkg::work_t in_work,
    output logic           out_valid,
    input  logic           out_ready,
    output ssc_pkg::work_t out_work
);

    localparam int PTR_W = $clog2(Depth);
    localparam int CNT_W = $clog2(Depth + 1);

    ssc_pkg::work_t   mem [Depth];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(Depth);
    assign out_valid = count_reg != '0;
    assign out_work  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_work;
        end
    end

endmodule

[hw/rtl/ssc_back.sv]
// ----------------------------------------------------------------------------
// ssc_back
// Holds the commutation and PI state, executes one work item per cycle while
// the result beat is not held, and registers the result beat.
// ----------------------------------------------------------------------------
module ssc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ssc_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ssc_pkg::work_t                in_work,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ssc_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int ACC_W = ssc_pkg::QUOT_W + 1;
    localparam int Y_W   = ssc_pkg::ERR_W + 2;

    logic [ssc_pkg::STEP_W-1:0]         drive_step_reg,    drive_step_next;
    logic [ssc_pkg::STEP_W-1:0]         crossing_step_reg, crossing_step_next;
    logic signed [ssc_pkg::INTEG_W-1:0] integral_reg,      integral_next;
    logic [ssc_pkg::DUTY_W-1:0]         duty_level_reg,    duty_level_next;
    logic                               m_tvalid_reg;
    logic [ssc_pkg::M_TDATA_W-1:0]      m_tdata_reg,       m_tdata_next;

    logic                               pop;
    logic signed [ACC_W-1:0]            quot_s;
    logic signed [ACC_W-1:0]            acc_raw;
    logic signed [ACC_W-1:0]            lim_s;
    logic signed [ACC_W-1:0]            acc;
    logic signed [Y_W-1:0]              y;
    logic [ssc_pkg::DUTY_W-1:0]         pi_duty;
    logic [5:0]                         pattern;
    logic [ssc_pkg::DUTY_W-1:0]         duty_a, duty_b, duty_c;
    logic [2:0]                         enables;
    logic                               accepted;

    assign in_ready = !m_tvalid_reg || m_tready;
    assign pop      = in_valid && in_ready;

    // clamped PI law: proportional gain of one, integral accumulates error / 100
    always_comb begin
        quot_s  = $signed({1'b0, in_work.quot});
        acc_raw = ACC_W'(integral_reg) + (in_work.err_neg ? -quot_s : quot_s);
        lim_s   = $signed({{(ACC_W - ssc_pkg::DUTY_W){1'b0}}, cfg.integral_limit});
        if (acc_raw > lim_s) begin
            acc = lim_s;
        end else if (acc_raw < -lim_s) begin
            acc = -lim_s;
        end else begin
            acc = acc_raw;
        end
        y = Y_W'(in_work.err) + Y_W'(acc)
            + $signed({{(Y_W - ssc_pkg::DUTY_W){1'b0}}, cfg.rest_duty});
        if (y > $signed({{(Y_W - ssc_pkg::DUTY_W){1'b0}}, cfg.max_duty})) begin
            pi_duty = cfg.max_duty;
        end else if (y < 0) begin
            pi_duty = '0;
        end else begin
            pi_duty = y[ssc_pkg::DUTY_W-1:0];
        end
    end

    always_comb begin
        drive_step_next    = drive_step_reg;
        crossing_step_next = crossing_step_reg;
        integral_next      = integral_reg;
        duty_level_next    = duty_level_reg;
        accepted           = 1'b0;
        pattern            = '0;

        case (in_work.op)
            ssc_pkg::OP_EDGE: begin
                if (in_work.xing.known && in_work.xing.need_step == crossing_step_reg) begin
                    accepted           = 1'b1;
                    drive_step_next    = in_work.xing.nxt_step;
                    crossing_step_next = in_work.xing.nxt_step;
                    if (in_work.sw_off) begin
                        duty_level_next = '0;
                    end else begin
                        duty_level_next = pi_duty;
                        integral_next   = acc[ssc_pkg::INTEG_W-1:0];
                    end
                end
            end
            ssc_pkg::OP_TICK: begin
                pattern = ssc_pkg::bridge_pattern(drive_step_reg);
            end
            ssc_pkg::OP_FORCE: begin
                // steps backwards; from step 0 or no step it wraps to the last step
                if (drive_step_reg == ssc_pkg::STEP_FIRST ||
                    drive_step_reg > ssc_pkg::STEP_NONE) begin
                    drive_step_next = ssc_pkg::STEP_LAST;
                end else begin
                    drive_step_next = drive_step_reg - 1'b1;
                end
                duty_level_next = in_work.sw_off ? '0 : cfg.force_duty;
            end
            default: begin
            end
        endcase

        duty_a  = pattern[0] ? duty_level_reg : '0;
        duty_b  = pattern[2] ? duty_level_reg : '0;
        duty_c  = pattern[4] ? duty_level_reg : '0;
        enables = {pattern[5] | pattern[4], pattern[3] | pattern[2], pattern[1] | pattern[0]};

        m_tdata_next = {1'b0, accepted, duty_level_next, drive_step_next, enables,
                        duty_c, duty_b, duty_a};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_step_reg    <= ssc_pkg::STEP_NONE;
            crossing_step_reg <= ssc_pkg::STEP_FIRST;
            integral_reg      <= '0;
            duty_level_reg    <= ssc_pkg::DUTY_LEVEL_RST;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (pop) begin
                drive_step_reg    <= drive_step_next;
                crossing_step_reg <= crossing_step_next;
                integral_reg      <= integral_next;
                duty_level_reg    <= duty_level_next;
            end
            if (in_ready) begin
                m_tvalid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hw/rtl/sensorless_six_step_commutator_top.sv]
// ----------------------------------------------------------------------------
// sensorless_six_step_commutator_top
// Sensorless six-step BLDC commutator with a clamped PI speed loop.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless stalled and returns one result beat per
// input beat, in order. A beat passes through the front end (speed multiply,
// then error and reciprocal multiply for the divide by 100), the queue and
// the output register. Throughput is one beat per cycle when nothing stalls,
// set by the back end, which updates the commutation/integral state as it
// takes each beat. Either side may stall on its own; the queue absorbs the
// front end while the output is held.
// Configuration writes are taken every cycle (cfg_ready is tied high) and must
// only be issued while no beat is in flight; indexes 6 and 7 are ignored.
module sensorless_six_step_commutator_top #(
    parameter int QueueDepth = ssc_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ssc_pkg::S_TUSER_W-1:0]     s_tuser,   // [1:0] operation
    input  logic [ssc_pkg::S_TDATA_W-1:0]     s_tdata,   // [1:0] phase, [2] rising,
                                                         // [18:3] elapsed_ticks,
                                                         // [19] switch_off
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ssc_pkg::M_TDATA_W-1:0]     m_tdata    // [7:0] duty_a, [15:8] duty_b,
                                                         // [23:16] duty_c, [24] enable_a,
                                                         // [25] enable_b, [26] enable_c,
                                                         // [29:27] step_now,
                                                         // [37:30] duty_now,
                                                         // [38] accepted
);

    ssc_pkg::cfg_t  cfg_reg;
    logic           fq_valid;
    logic           fq_ready;
    ssc_pkg::work_t fq_work;
    logic           qb_valid;
    logic           qb_ready;
    ssc_pkg::work_t qb_work;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_speed   <= ssc_pkg::TARGET_SPEED_RST;
            cfg_reg.speed_scale    <= ssc_pkg::SPEED_SCALE_RST;
            cfg_reg.rest_duty      <= ssc_pkg::REST_DUTY_RST;
            cfg_reg.max_duty       <= ssc_pkg::MAX_DUTY_RST;
            cfg_reg.integral_limit <= ssc_pkg::INTEGRAL_LIMIT_RST;
            cfg_reg.force_duty     <= ssc_pkg::FORCE_DUTY_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ssc_pkg::CFG_TARGET_SPEED:   cfg_reg.target_speed   <= cfg_data;
                ssc_pkg::CFG_SPEED_SCALE:    cfg_reg.speed_scale    <= cfg_data[7:0];
                ssc_pkg::CFG_REST_DUTY:      cfg_reg.rest_duty      <= cfg_data[7:0];
                ssc_pkg::CFG_MAX_DUTY:       cfg_reg.max_duty       <= cfg_data[7:0];
                ssc_pkg::CFG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= cfg_data[7:0];
                ssc_pkg::CFG_FORCE_DUTY:     cfg_reg.force_duty     <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    ssc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_work  (fq_work)
    );

    ssc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_work   (fq_work),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_work  (qb_work)
    );

    ssc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (qb_valid),
        .in_ready (qb_ready),
        .in_work  (qb_work),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
